/* hw/rtl/ccr_pkg.sv */
`timescale 1ns / 1ps

package ccr_pkg;

	typedef enum logic [2:0] {
		ACT_CONFIGURE = 3'd0,
		ACT_SAMPLE    = 3'd1,
		ACT_TICK      = 3'd2,
		ACT_POLL      = 3'd3,
		ACT_PRESET    = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		MODE_AUTO      = 2'd0,
		MODE_NOT_EQUAL = 2'd1,
		MODE_DEADBAND  = 2'd2,
		MODE_THRESHOLD = 2'd3
	} mode_t;

	localparam logic [1:0] EDGE_RISING  = 2'd0;
	localparam logic [1:0] EDGE_FALLING = 2'd1;
	localparam logic [1:0] EDGE_BOTH    = 2'd2;

	localparam int          ChanW          = 5;
	localparam int          ValW           = 32;
	localparam logic [31:0] DEFAULT_PERIOD = 32'd100;
	// analog samples are kept only in 0..1023: everything above bit 9 must be clear
	localparam int          AnalogBits     = 10;

	// one channel's stored state, one RAM word
	typedef struct packed {
		logic signed [ValW-1:0] current;
		logic signed [ValW-1:0] reported;
		mode_t                  mode;
		logic [31:0]            period;
		logic signed [ValW-1:0] level;
		logic [1:0]             edge_sel;
		logic [31:0]            last_fire;
	} ccr_rec_t;

	localparam ccr_rec_t REC_RESET = '{
		current:   32'sd1,
		reported:  32'sd1,
		mode:      MODE_NOT_EQUAL,
		period:    DEFAULT_PERIOD,
		level:     32'sd0,
		edge_sel:  EDGE_RISING,
		last_fire: 32'd0
	};

endpackage

/* hw/rtl/ccr_in_if.sv */
`timescale 1ns / 1ps

interface ccr_in_if import ccr_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [2:0]             action;
	logic [ChanW-1:0]       channel;
	logic [1:0]             mode;
	logic [31:0]            period_ms;
	logic signed [ValW-1:0] level;
	logic [1:0]             edge_req;
	logic signed [ValW-1:0] sample_value;
	logic                   is_analog;

	modport source (
		output valid, action, channel, mode, period_ms, level, edge_req,
			sample_value, is_analog,
		input  ready
	);

	modport sink (
		input  valid, action, channel, mode, period_ms, level, edge_req,
			sample_value, is_analog,
		output ready
	);
endinterface

/* hw/rtl/ccr_out_if.sv */
`timescale 1ns / 1ps

interface ccr_out_if import ccr_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic                   report;
	logic [ChanW-1:0]       report_channel;
	logic signed [ValW-1:0] report_value;

	modport source (
		output valid, report, report_channel, report_value,
		input  ready
	);

	modport sink (
		input  valid, report, report_channel, report_value,
		output ready
	);
endinterface

/* hw/rtl/ccr_ram.sv */
`timescale 1ns / 1ps

module ccr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 24,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/channel_change_reporter_top.sv */
`timescale 1ns / 1ps

// Report-on-change engine for NUM_CHANNELS channels. Every input word carries one action
// (configure, sample, tick, poll, preset) and gives exactly one result word: report is set
// when a due poll decides the channel's value must go out, report_channel echoes the channel
// and report_value is the channel's current value after the action (0 for a channel index
// at or above NUM_CHANNELS). A word can be accepted on every clock unless stage 1 is held by a
// stalled output. Its result is offered once it has passed stage 1 into the output register.
// The path runs through the per-channel state RAM: its read port is clocked at acceptance,
// the registered read data feeds one stage of compare logic that writes the updated entry
// back, and the result lands in the output register. A word that follows on the same channel
// picks up the just-written entry from a bypass register.
// Each entry has a valid flip-flop cleared by reset; an unwritten entry reads as the
// power-up defaults (value 1, not-equal mode, 100 ms period), so there is no clearing pass.
module channel_change_reporter_top import ccr_pkg::*; #(
	parameter int NUM_CHANNELS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	ccr_in_if.sink    samples,
	ccr_out_if.source results
);

	localparam int AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int RW  = $bits(ccr_rec_t);
	localparam int CmpW = 7;

	// handshake
	logic accept;
	logic adv;

	// stage 1: accepted word, RAM read data arrives alongside
	logic                   valid_s1;
	action_t                action_s1;
	logic [ChanW-1:0]       channel_s1;
	logic                   ch_ok_s1;
	logic [AW-1:0]          addr_s1;
	mode_t                  mode_s1;
	logic [31:0]            period_s1;
	logic signed [ValW-1:0] level_s1;
	logic [1:0]             edge_s1;
	logic signed [ValW-1:0] value_s1;
	logic                   analog_s1;
	logic                   rd_valid_s1;

	// output register
	logic                   out_valid_s2;
	logic                   report_s2;
	logic [ChanW-1:0]       channel_s2;
	logic signed [ValW-1:0] value_s2;

	logic [31:0]             now_ms_q;
	logic [NUM_CHANNELS-1:0] entry_valid_q;
	logic                    fwd_hit_q;
	ccr_rec_t                fwd_rec_q;

	logic             in_ch_ok;
	logic [AW-1:0]    in_addr;
	logic [RW-1:0]    ram_rdata;
	ccr_rec_t         rec_cur;
	ccr_rec_t         rec_nxt;
	logic             report_nxt;
	logic             ram_we;

	logic [31:0]            elapsed;
	logic signed [ValW+1:0] band_hi;
	logic signed [ValW+1:0] band_lo;
	logic signed [ValW+1:0] last_x;
	logic                   rise_hit;
	logic                   fall_hit;

	assign adv            = valid_s1 && (!out_valid_s2 || results.ready);
	assign samples.ready  = !valid_s1 || adv;
	assign accept         = samples.valid && samples.ready;
	assign in_ch_ok       = CmpW'(samples.channel) < CmpW'(NUM_CHANNELS);
	assign in_addr        = AW'(samples.channel);
	assign ram_we         = adv && ch_ok_s1;

	ccr_ram #(
		.WIDTH (RW),
		.DEPTH (NUM_CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (rec_nxt),
		.re    (accept),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_s2  <= 1'b0;
			now_ms_q      <= '0;
			entry_valid_q <= '0;
			fwd_hit_q     <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_s2 <= 1'b1;
			end else if (results.ready) begin
				out_valid_s2 <= 1'b0;
			end
			if (adv && action_s1 == ACT_TICK) begin
				now_ms_q <= now_ms_q + 32'd1;
			end
			if (ram_we) begin
				entry_valid_q[addr_s1] <= 1'b1;
			end
			// RAM read at this edge misses the write at the same edge: bypass it
			if (accept) begin
				fwd_hit_q <= ram_we && in_ch_ok && (in_addr == addr_s1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= action_t'(samples.action);
			channel_s1  <= samples.channel;
			ch_ok_s1    <= in_ch_ok;
			addr_s1     <= in_addr;
			mode_s1     <= mode_t'(samples.mode);
			period_s1   <= samples.period_ms;
			level_s1    <= samples.level;
			edge_s1     <= samples.edge_req;
			value_s1    <= samples.sample_value;
			analog_s1   <= samples.is_analog;
			rd_valid_s1 <= in_ch_ok && entry_valid_q[in_addr];
			fwd_rec_q   <= rec_nxt;
		end
		if (adv) begin
			report_s2  <= report_nxt;
			channel_s2 <= channel_s1;
			value_s2   <= ch_ok_s1 ? rec_nxt.current : '0;
		end
	end

	// entry as seen by the word in stage 1
	always_comb begin
		if (fwd_hit_q) begin
			rec_cur = fwd_rec_q;
		end else if (rd_valid_s1) begin
			rec_cur = ccr_rec_t'(ram_rdata);
		end else begin
			rec_cur = REC_RESET;
		end
	end

	// poll decision terms; deadband sums carried two bits wider so they cannot wrap
	assign elapsed  = now_ms_q - rec_cur.last_fire;
	assign band_hi  = (ValW+2)'(rec_cur.current) + (ValW+2)'(rec_cur.level);
	assign band_lo  = (ValW+2)'(rec_cur.current) - (ValW+2)'(rec_cur.level);
	assign last_x   = (ValW+2)'(rec_cur.reported);
	assign rise_hit = (rec_cur.edge_sel == EDGE_RISING || rec_cur.edge_sel == EDGE_BOTH)
		&& (rec_cur.reported <= rec_cur.level) && (rec_cur.current > rec_cur.level);
	assign fall_hit = (rec_cur.edge_sel == EDGE_FALLING || rec_cur.edge_sel == EDGE_BOTH)
		&& (rec_cur.reported > rec_cur.level) && (rec_cur.current <= rec_cur.level);

	always_comb begin
		rec_nxt    = rec_cur;
		report_nxt = 1'b0;
		if (ch_ok_s1) begin
			case (action_s1)
				ACT_CONFIGURE: begin
					rec_nxt.mode      = mode_s1;
					rec_nxt.period    = period_s1;
					rec_nxt.last_fire = now_ms_q;
					if (mode_s1 == MODE_DEADBAND || mode_s1 == MODE_THRESHOLD) begin
						rec_nxt.level = level_s1;
					end
					if (mode_s1 == MODE_THRESHOLD) begin
						rec_nxt.edge_sel = edge_s1;
					end
				end
				ACT_SAMPLE: begin
					if (!analog_s1 || (value_s1[ValW-1:AnalogBits] == '0)) begin
						rec_nxt.current = value_s1;
					end
				end
				ACT_POLL: begin
					if (elapsed >= rec_cur.period) begin
						rec_nxt.last_fire = now_ms_q;
						case (rec_cur.mode)
							MODE_AUTO: begin
								rec_nxt.reported = rec_cur.current;
								report_nxt       = 1'b1;
							end
							MODE_NOT_EQUAL: begin
								if (rec_cur.current != rec_cur.reported) begin
									rec_nxt.reported = rec_cur.current;
									report_nxt       = 1'b1;
								end
							end
							MODE_DEADBAND: begin
								if ((last_x > band_hi || last_x < band_lo)
									&& rec_cur.current >= rec_cur.level) begin
									rec_nxt.reported = rec_cur.current;
									report_nxt       = 1'b1;
								end
							end
							default: begin
								rec_nxt.reported = rec_cur.current;
								report_nxt       = rise_hit || fall_hit;
							end
						endcase
					end
				end
				ACT_PRESET: begin
					rec_nxt.current  = value_s1;
					rec_nxt.reported = value_s1;
				end
				default: begin
				end
			endcase
		end
	end

	assign results.valid          = out_valid_s2;
	assign results.report         = report_s2;
	assign results.report_channel = channel_s2;
	assign results.report_value   = value_s2;

	// a report only ever names a real channel
	a_report_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.report
			|-> (CmpW'(results.report_channel) < CmpW'(NUM_CHANNELS)))
		else $error("report raised for a channel outside the table");

	// out-of-range channels give a zero value and never write the table
	a_oor_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ch_ok_s1 |-> !ram_we && !report_nxt)
		else $error("out-of-range channel touched the state table");

	// a tick moves the clock by exactly one
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && action_s1 == ACT_TICK |=> now_ms_q == $past(now_ms_q) + 32'd1)
		else $error("tick did not advance the millisecond count by one");

	// input is held off only by a full stage 1 behind a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> valid_s1 && out_valid_s2 && !results.ready)
		else $error("input stalled without a full pipeline");

	// a bypass hit is only ever consumed by an occupied stage 1
	a_fwd_owner: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit_q && !valid_s1 |-> !adv)
		else $error("bypass flag set with no word in stage 1");

endmodule
